// ===== src/ilist_pkg.sv =====
// ----------------------------------------------------------------------------
// ilist_pkg
// types, codes and defaults shared by the indexed list block
// ----------------------------------------------------------------------------
package ilist_pkg;

   localparam int DEF_CAPACITY   = 64;
   localparam int DEF_DATA_WIDTH = 32;

   // fixed field widths of the request and response items
   localparam int ACTION_W = 2;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int FIDX_W   = 6;
   localparam int COUNT_W  = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT = 2'd0,
      ACT_ERASE  = 2'd1,
      ACT_FIND   = 2'd2,
      ACT_NONE   = 2'd3
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE    = 2'd0,
      ST_BAD_POS = 2'd1,
      ST_FULL    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_DRAIN,
      S_PUT,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request fields
      logic judge;     // latch result status
      logic start;     // set walk pointers, update count
      logic rd_en;     // read list at walk pointer
      logic put;       // write new word at position
      logic rsp_load;  // load response register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      action_type act;
      status_type code;
      logic       empty_run;  // no entries to walk
      logic       last;       // walk pointer at end index
      logic       hit;        // find matched this cycle
   } sts_type;

endpackage

// ===== src/ilist_ctrl.sv =====
// ----------------------------------------------------------------------------
// ilist_ctrl
// request sequencer: decide, walk the list, write, hand off the response
// ----------------------------------------------------------------------------
module ilist_ctrl import ilist_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            cmd.judge = 1'b1;
            if (sts.code != ST_DONE || sts.act == ACT_NONE) begin
               state_in = S_FINISH;
            end else begin
               cmd.start = 1'b1;
               if (!sts.empty_run) begin
                  state_in = S_SCAN;
               end else if (sts.act == ACT_INSERT) begin
                  state_in = S_PUT;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            if (sts.hit) begin
               state_in = S_FINISH;
            end else begin
               cmd.rd_en = 1'b1;
               if (sts.last) state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = (sts.act == ACT_INSERT) ? S_PUT : S_FINISH;
         end
         S_PUT: begin
            cmd.put  = 1'b1;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== src/ilist_dpath.sv =====
// ----------------------------------------------------------------------------
// ilist_dpath
// list memory, count, walk pointers, compare and response register
// ----------------------------------------------------------------------------
module ilist_dpath import ilist_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  cmd_type                    cmd,
   output sts_type                    sts,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic [FIDX_W-1:0]          rsp_found_index,
   output logic [COUNT_W-1:0]         rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   action_type            act_ff;
   logic [POS_W-1:0]      pos_ff;
   logic [DATA_WIDTH-1:0] word_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         ptr_ff, ptr_in;
   logic [AW-1:0]         end_ff;
   logic [AW-1:0]         rdaddr_ff;
   logic                  rdv_ff;
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic                  found_ff;
   logic [AW-1:0]         fidx_ff;
   status_type            stat_ff;

   logic [STATUS_W-1:0]   rsp_status_ff;
   logic                  rsp_found_ff;
   logic [FIDX_W-1:0]     rsp_fidx_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;

   logic [PW-1:0]         pos_w, cnt_w;
   logic                  pos_bad, full;
   status_type            code;
   logic                  empty_run;
   logic [AW-1:0]         ptr_start, end_start;
   logic                  hit;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;

   assign pos_w = PW'(pos_ff);
   assign cnt_w = PW'(count_ff);
   assign full  = (count_ff == CW'(CAPACITY));

   always_comb begin
      pos_bad   = 1'b0;
      code      = ST_DONE;
      empty_run = 1'b1;
      ptr_start = '0;
      end_start = AW'(count_ff - CW'(1));
      case (act_ff)
         ACT_INSERT: begin
            pos_bad   = (pos_w > cnt_w);
            code      = pos_bad ? ST_BAD_POS : (full ? ST_FULL : ST_DONE);
            empty_run = (pos_w == cnt_w);
            ptr_start = AW'(count_ff - CW'(1));
            end_start = AW'(pos_ff);
         end
         ACT_ERASE: begin
            pos_bad   = (pos_w >= cnt_w);
            code      = pos_bad ? ST_BAD_POS : ST_DONE;
            empty_run = ((pos_w + PW'(1)) == cnt_w);
            ptr_start = AW'(pos_w + PW'(1));
         end
         ACT_FIND: begin
            empty_run = (count_ff == '0);
         end
         default: begin
            empty_run = 1'b1;
         end
      endcase
   end

   assign hit = rdv_ff && (act_ff == ACT_FIND) && (rd_data_ff == word_ff) && !found_ff;

   assign sts.act       = act_ff;
   assign sts.code      = code;
   assign sts.empty_run = empty_run;
   assign sts.last      = (ptr_ff == end_ff);
   assign sts.hit       = hit;

   // count and walk pointer
   always_comb begin
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.start) begin
         ptr_in = ptr_start;
         if (act_ff == ACT_INSERT) count_in = count_ff + CW'(1);
         if (act_ff == ACT_ERASE)  count_in = count_ff - CW'(1);
      end else if (cmd.rd_en) begin
         ptr_in = (act_ff == ACT_INSERT) ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         count_ff <= count_in;
         rdv_ff   <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load) begin
         act_ff   <= action_type'(req_action);
         pos_ff   <= req_position;
         word_ff  <= DATA_WIDTH'(req_value);
         found_ff <= 1'b0;
         fidx_ff  <= '0;
      end else if (hit) begin
         found_ff <= 1'b1;
         fidx_ff  <= rdaddr_ff;
      end
      if (cmd.judge) stat_ff <= code;
      if (cmd.start) end_ff <= end_start;
      if (cmd.rd_en) rdaddr_ff <= ptr_ff;
      if (cmd.rsp_load) begin
         rsp_status_ff <= stat_ff;
         rsp_found_ff  <= found_ff;
         rsp_fidx_ff   <= FIDX_W'(fidx_ff);
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   // shift write of the registered read word to its neighbour slot, or the new word
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rdaddr_ff;
      wr_data = rd_data_ff;
      if (cmd.put) begin
         wr_en   = 1'b1;
         wr_addr = AW'(pos_ff);
         wr_data = word_ff;
      end else if (rdv_ff && act_ff == ACT_INSERT) begin
         wr_en   = 1'b1;
         wr_addr = rdaddr_ff + AW'(1);
      end else if (rdv_ff && act_ff == ACT_ERASE) begin
         wr_en   = 1'b1;
         wr_addr = rdaddr_ff - AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.rd_en) rd_data_ff <= mem[ptr_ff];
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_index = rsp_fidx_ff;
   assign rsp_count       = rsp_count_ff;

endmodule

// ===== src/indexed_list_insert_erase_find.sv =====
// ----------------------------------------------------------------------------
// indexed_list_insert_erase_find
// insert and erase walk the entries between the position and the end of the list;
// find walks from the front until the first match; appends, pops from the back,
// finds in an empty list and refused or unused requests skip the walk
// one item at a time: the next request is taken in the cycle after the response
// loads, later while an earlier response is still stalled; the walk reads one
// list entry per cycle and writes each one in the cycle after its read
// reset clears the count and the control state; list contents stay undefined
// until written and need no clearing pass
// ----------------------------------------------------------------------------
module indexed_list_insert_erase_find import ilist_pkg::*; #(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                       clock,
   input  logic                       reset,
   // request item
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VALUE_W-1:0]  req_value,
   // response item
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_found,
   output logic [FIDX_W-1:0]          rsp_found_index,
   output logic [COUNT_W-1:0]         rsp_count
);

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // sequencer: takes one request when idle, steps the walk, and holds the
   // finished response until the response register is free
   ilist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: list memory with registered read, count, walk pointers,
   // match compare and the response register
   ilist_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_value       (req_value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

endmodule

// ===== src/ilist_chk.sv =====
// ----------------------------------------------------------------------------
// ilist_chk
// port-level checks for the indexed list block, bound to the top level
// ----------------------------------------------------------------------------
module ilist_chk import ilist_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic [ACTION_W-1:0]       req_action,
   input logic [POS_W-1:0]          req_position,
   input logic signed [VALUE_W-1:0] req_value,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic                      rsp_found,
   input logic [FIDX_W-1:0]         rsp_found_index,
   input logic [COUNT_W-1:0]        rsp_count
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found) && $stable(rsp_found_index) && $stable(rsp_count))
      else $error("stalled response changed");

   // refused request never reports a match
   a_refused_no_find: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> !rsp_found)
      else $error("refused request reports a match");

   // no match means index zero
   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_found_index == '0)
      else $error("miss with nonzero index");

   // count stays within capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (CAPACITY > 127) || (32'(rsp_count) <= CAPACITY))
      else $error("count above capacity");

   // nothing is pending and no stall is raised right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response or stall right after reset");

endmodule

bind indexed_list_insert_erase_find ilist_chk #(.CAPACITY(CAPACITY)) u_chk (.*);

// ===== sim/indexed_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_checker
// watches the request and response channels of the indexed list, keeps its
// own copy of the list and count, works out each reply and compares it field
// by field with the replies the block returns, in order
// ----------------------------------------------------------------------------
module indexed_list_checker import ilist_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [ACTION_W-1:0]        req_action,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [STATUS_W-1:0]        rsp_status,
   input  logic                       rsp_found,
   input  logic [FIDX_W-1:0]          rsp_found_index,
   input  logic [COUNT_W-1:0]         rsp_count,
   output int                         fail_count,
   output int                         pending,
   output int                         fill_level,
   output int                         checked,
   output int                         hit_count,
   output int                         refused_count,
   output int                         full_visits
);

   typedef struct {
      status_type          status;
      logic                found;
      logic [FIDX_W-1:0]   index;
      logic [COUNT_W-1:0]  count;
   } list_reply_type;

   list_reply_type        replies_due[$];
   logic [VALUE_W-1:0]    shadow_words [CAPACITY];
   int                    shadow_count;

   // applies one request to the shadow list and returns the reply it earns
   function automatic list_reply_type apply_request(action_type act,
                                                    logic [POS_W-1:0] pos,
                                                    logic [VALUE_W-1:0] word);
      list_reply_type r;
      int             k;
      bit             seeking;
      r.status = ST_DONE;
      r.found  = 1'b0;
      r.index  = '0;
      seeking  = 1'b1;
      case (act)
         ACT_INSERT: begin
            if (int'(pos) > shadow_count) begin
               r.status = ST_BAD_POS;
            end else if (shadow_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (k = shadow_count; k > int'(pos); k--)
                  shadow_words[k] = shadow_words[k-1];
               shadow_words[pos] = word;
               shadow_count++;
            end
         end
         ACT_ERASE: begin
            if (int'(pos) >= shadow_count) begin
               r.status = ST_BAD_POS;
            end else begin
               for (k = int'(pos) + 1; k < shadow_count; k++)
                  shadow_words[k-1] = shadow_words[k];
               shadow_count--;
            end
         end
         ACT_FIND: begin
            for (k = 0; k < shadow_count; k++) begin
               if (seeking && shadow_words[k] == word) begin
                  r.found = 1'b1;
                  r.index = FIDX_W'(k);
                  seeking = 1'b0;
               end
            end
         end
         default: ;
      endcase
      r.count = COUNT_W'(shadow_count);
      return r;
   endfunction

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         shadow_count = 0;
         replies_due.delete();
      end else begin
         // the reply leaving now belongs to an older request, so take it first
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: reply with no request outstanding: status %0d count %0d",
                           $realtime, rsp_status, rsp_count);
            end else begin
               want = replies_due.pop_front();
               checked++;
               if (rsp_status !== want.status || rsp_found !== want.found ||
                   rsp_found_index !== want.index || rsp_count !== want.count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: reply %0d mismatch: expected status %0d found %0b ",
                               "index %0d count %0d, got status %0d found %0b index %0d ",
                               "count %0d"}, $realtime, checked, want.status, want.found,
                              want.index, want.count, rsp_status, rsp_found,
                              rsp_found_index, rsp_count);
               end
            end
         end
         if (req_valid && !req_stall) begin
            want = apply_request(action_type'(req_action), req_position, req_value);
            replies_due.push_back(want);
            if (want.found)
               hit_count++;
            if (want.status != ST_DONE)
               refused_count++;
            if (action_type'(req_action) == ACT_INSERT && want.status == ST_DONE &&
                shadow_count == CAPACITY)
               full_visits++;
         end
      end
      pending    = replies_due.size();
      fill_level = shadow_count;
   end

endmodule

// ===== sim/indexed_list_insert_erase_find_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_erase_find_test
// drives insert, erase and find requests into the indexed list, first a short
// directed set around the edges, then random runs that fill the list to
// capacity and drain it to empty; a checker beside the block predicts and
// compares every reply
// ----------------------------------------------------------------------------
module indexed_list_insert_erase_find_test;
   import ilist_pkg::*;

   localparam int LIST_DEPTH  = DEF_CAPACITY;
   localparam int RANDOM_REQS = 1180;
   localparam int CALM_REQS   = 150;     // tail of the run with no idling at all
   localparam int CYCLE_LIMIT = 500000;
   localparam int HOLD_CYCLES = 400;     // long output hold that backs up the block
   localparam int POS_MAX     = (1 << POS_W) - 1;

   // bias of the random requests: fill up, drain down, or a mix
   typedef enum {TREND_GROW, TREND_SHRINK, TREND_MIXED} fill_trend_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [ACTION_W-1:0]       req_action;
   logic [POS_W-1:0]          req_position;
   logic signed [VALUE_W-1:0] req_value;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [STATUS_W-1:0]       rsp_status;
   logic                      rsp_found;
   logic [FIDX_W-1:0]         rsp_found_index;
   logic [COUNT_W-1:0]        rsp_count;

   int fail_count;
   int pending;
   int fill_level;
   int checked;
   int hit_count;
   int refused_count;
   int full_visits;
   int cycles;
   bit calm;         // set for the last part of the run: no gaps, no stalls

   indexed_list_insert_erase_find #(
      .CAPACITY   (LIST_DEPTH),
      .DATA_WIDTH (DEF_DATA_WIDTH)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count)
   );

   indexed_list_checker #(
      .CAPACITY (LIST_DEPTH)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_position    (req_position),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count),
      .fail_count      (fail_count),
      .pending         (pending),
      .fill_level      (fill_level),
      .checked         (checked),
      .hit_count       (hit_count),
      .refused_count   (refused_count),
      .full_visits     (full_visits)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // places one item on the request port and holds it until it is taken;
   // called right after a falling edge
   task automatic drive_item(action_type act, logic [POS_W-1:0] pos,
                             logic [VALUE_W-1:0] word);
      req_valid    <= 1'b1;
      req_action   <= act;
      req_position <= pos;
      req_value    <= word;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // directed items: wait for the falling edge, then offer
   task automatic offer(action_type act, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] word);
      @(negedge clock);
      drive_item(act, pos, word);
   endtask

   // words: mostly a handful of small values so finds hit and duplicates
   // appear, plus the extremes and fully random words
   function automatic logic [VALUE_W-1:0] pick_word();
      int roll;
      int small_word;
      roll       = $urandom_range(7);
      small_word = $urandom_range(7);
      if (roll < 4)
         return VALUE_W'(small_word - 3);
      else if (roll == 4)
         case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      else
         return $urandom();
   endfunction

   // positions: mostly legal for the current fill, some at the ends, some
   // anywhere in the field
   function automatic logic [POS_W-1:0] pick_position(action_type act);
      int roll;
      int top_pos;
      roll    = $urandom_range(9);
      top_pos = (act == ACT_INSERT) ? fill_level : fill_level - 1;
      if (roll >= 8 || act == ACT_FIND || act == ACT_NONE)
         return POS_W'($urandom_range(POS_MAX));
      else if (top_pos < 0)
         return '0;
      else if (roll == 7)
         return ($urandom_range(1) != 0) ? POS_W'(top_pos) : '0;
      else
         return POS_W'($urandom_range(top_pos));
   endfunction

   function automatic action_type pick_action(fill_trend_type trend);
      int roll;
      int ins_pct;
      int era_pct;
      roll = $urandom_range(99);
      case (trend)
         TREND_GROW:   begin ins_pct = 75; era_pct = 10; end
         TREND_SHRINK: begin ins_pct = 10; era_pct = 75; end
         default:      begin ins_pct = 35; era_pct = 30; end
      endcase
      if (roll < ins_pct)
         return ACT_INSERT;
      else if (roll < ins_pct + era_pct)
         return ACT_ERASE;
      else if (roll < 97)
         return ACT_FIND;
      else
         return ACT_NONE;
   endfunction

   function automatic int pick_rate();
      case ($urandom_range(3))
         0:       return 0;
         1:       return 3;
         2:       return 10;
         default: return 30;
      endcase
   endfunction

   // receiver: random stall bursts, the rate changing now and then, one long
   // hold so the block backs up its input, and nothing in the calm tail
   initial begin : receiver
      int burst;
      int rate;
      int tick;
      bit held_once;
      rsp_stall = 1'b0;
      burst     = 0;
      rate      = 0;
      tick      = 0;
      held_once = 1'b0;
      forever begin
         @(negedge clock);
         tick++;
         if (tick % 200 == 0)
            rate = pick_rate();
         if (!held_once && checked >= 300 && !calm) begin
            held_once = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            burst = 0;
         end else if (burst > 0 && !calm) begin
            rsp_stall <= 1'b1;
            burst--;
         end else if (!calm && $urandom_range(99) < rate) begin
            rsp_stall <= 1'b1;
            burst = $urandom_range(13, 1) - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // sender
   initial begin : stimulus
      action_type         act;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] word;
      fill_trend_type     trend;
      int                 tx_rate;
      int                 gap;
      int                 n;
      req_valid    = 1'b0;
      req_action   = ACT_INSERT;
      req_position = '0;
      req_value    = '0;
      reset        = 1'b1;
      calm         = 1'b0;
      trend        = TREND_GROW;
      tx_rate      = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty list: erase and insert past the end are refused, find misses
      offer(ACT_ERASE,  0,   32'h0000_0000);
      offer(ACT_FIND,   0,   32'h0000_0000);
      offer(ACT_INSERT, 1,   32'h0000_0001);
      // unused action code leaves the list alone
      offer(ACT_NONE,   127, 32'hffff_ffff);
      // build [-1, min, 5, max, 0, 5] with front, end and middle inserts
      offer(ACT_INSERT, 0,   32'h8000_0000);
      offer(ACT_INSERT, 1,   32'h7fff_ffff);
      offer(ACT_INSERT, 0,   32'hffff_ffff);
      offer(ACT_INSERT, 3,   32'h0000_0000);
      offer(ACT_INSERT, 2,   32'h0000_0005);
      offer(ACT_INSERT, 5,   32'h0000_0005);
      // duplicates report the lowest index; index 0 is searched too
      offer(ACT_FIND,   99,  32'h0000_0005);
      offer(ACT_FIND,   0,   32'h8000_0000);
      offer(ACT_FIND,   0,   32'hffff_ffff);
      offer(ACT_FIND,   127, 32'h0000_0000);
      offer(ACT_FIND,   0,   32'h0000_3039);
      // largest position, erase at count, then pop back and pop front
      offer(ACT_INSERT, 127, 32'h0000_0001);
      offer(ACT_ERASE,  6,   32'h0000_0000);
      offer(ACT_ERASE,  5,   32'h0000_0000);
      offer(ACT_ERASE,  0,   32'h0000_0000);
      offer(ACT_FIND,   0,   32'hffff_ffff);
      offer(ACT_ERASE,  2,   32'h0000_0000);
      offer(ACT_NONE,   0,   32'h0000_0000);
      offer(ACT_FIND,   0,   32'h7fff_ffff);

      // random part: trends walk the fill between empty and full so that
      // inserts into a full list and erases from an empty one both occur
      for (n = 0; n < RANDOM_REQS; n++) begin
         if (n % 100 == 0)
            tx_rate = pick_rate();
         if (n == RANDOM_REQS - CALM_REQS)
            calm = 1'b1;
         // one pause that lets every outstanding reply come home
         if (n == 600) begin
            @(negedge clock);
            req_valid <= 1'b0;
            while (pending != 0)
               @(negedge clock);
         end
         if (!calm && $urandom_range(99) < tx_rate) begin
            gap = $urandom_range(13, 1);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         @(negedge clock);
         // fill is current here: the last acceptance was at the rising edge
         if (trend == TREND_GROW && fill_level == LIST_DEPTH && $urandom_range(3) == 0)
            trend = TREND_SHRINK;
         else if (trend == TREND_SHRINK && fill_level == 0 && $urandom_range(3) == 0)
            trend = ($urandom_range(1) != 0) ? TREND_GROW : TREND_MIXED;
         else if (trend == TREND_MIXED && $urandom_range(59) == 0)
            trend = TREND_GROW;
         act  = pick_action(trend);
         pos  = pick_position(act);
         word = pick_word();
         drive_item(act, pos, word);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      // longest walk is a front insert into a list one short of full
      repeat (LIST_DEPTH + 16) @(posedge clock);

      $display("covered %0d requests, %0d replies checked: %0d find hits, %0d refused,",
               RANDOM_REQS + 23, checked, hit_count, refused_count);
      $display("list filled to capacity %0d times, one long output hold, one full drain",
               full_visits);
      if (fail_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
src/ilist_pkg.sv
src/ilist_ctrl.sv
src/ilist_dpath.sv
src/indexed_list_insert_erase_find.sv
src/ilist_chk.sv
sim/indexed_list_checker.sv
sim/indexed_list_insert_erase_find_test.sv
